// ===== sv/acrs_pkg.sv =====
// Shared types, constants and helpers of the ADC conversion request sequencer.
package acrs_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam int STATUS_RDY_BIT = 2;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef enum logic {
		FUNC_ENQ = 1'b0,
		FUNC_POLL = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_RESULT = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_DROP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_DROP,
		ST_START_NEW,
		ST_POLL_CMP,
		ST_START_WAIT,
		ST_START_OLD
	} state_t;

	typedef struct packed {
		logic [3:0] sensor_id;
		logic [3:0] pos_channel;
		logic [3:0] neg_channel;
		logic [2:0] gain;
	} entry_t;

	typedef struct packed {
		func_t func;
		logic [3:0] sensor_id;
		logic [3:0] pos_channel;
		logic [3:0] neg_channel;
		logic [2:0] gain;
		logic [7:0] status_byte;
		logic [23:0] raw_data;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] sensor;
		logic [3:0] pos_channel;
		logic [3:0] neg_channel;
		logic [2:0] gain;
		logic [23:0] value;
		logic last;
	} emit_t;

	typedef struct packed {
		logic en;
		ptr_t addr;
		entry_t data;
	} ring_wr_t;

	function automatic ptr_t next_slot(input ptr_t p);
		ptr_t r;
		if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== sv/acrs_ifs.sv =====
// Valid/ready channel interfaces for request words and result words.
interface acrs_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [3:0] sensor_id;
	logic [3:0] pos_channel;
	logic [3:0] neg_channel;
	logic [2:0] gain;
	logic [7:0] status_byte;
	logic [23:0] raw_data;
	logic [31:0] now_ms;

	modport source (
		output valid, func, sensor_id, pos_channel, neg_channel, gain,
		status_byte, raw_data, now_ms,
		input ready
	);
	modport sink (
		input valid, func, sensor_id, pos_channel, neg_channel, gain,
		status_byte, raw_data, now_ms,
		output ready
	);
endinterface

interface acrs_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [3:0] out_sensor;
	logic [3:0] out_pos_channel;
	logic [3:0] out_neg_channel;
	logic [2:0] out_gain;
	logic signed [23:0] value;
	logic last;

	modport source (
		output valid, kind, out_sensor, out_pos_channel, out_neg_channel, out_gain,
		value, last,
		input ready
	);
	modport sink (
		input valid, kind, out_sensor, out_pos_channel, out_neg_channel, out_gain,
		value, last,
		output ready
	);
endinterface

// ===== sv/acrs_ring.sv =====
// Request ring storage: one write port, one registered read port.
module acrs_ring (
	input logic clk,
	input acrs_pkg::ring_wr_t wr,
	input acrs_pkg::ptr_t rd_addr,
	output acrs_pkg::entry_t rd_data
);

	acrs_pkg::entry_t mem_q [acrs_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/acrs_seq.sv =====
// Sequencer: ring pointers, duplicate scan, poll decision and result issue.
module acrs_seq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input acrs_pkg::item_t item,
	input logic [15:0] timeout_ms,
	output logic emit_valid,
	output acrs_pkg::emit_t emit,
	input logic out_free,
	output acrs_pkg::ring_wr_t ring_wr,
	output acrs_pkg::ptr_t rd_addr,
	input acrs_pkg::entry_t rd_data
);

	acrs_pkg::state_t state_q, state_d;
	acrs_pkg::ptr_t head_q, tail_q, scan_q;
	logic [31:0] stamp_q;
	acrs_pkg::item_t item_q;

	logic empty, full, more, scan_end, dup, data_rdy, timed_out, retire, emit_go;
	logic [31:0] elapsed;
	acrs_pkg::ptr_t head_nx;

	assign head_nx = acrs_pkg::next_slot(head_q);
	assign empty = (head_q == tail_q);
	assign full = (acrs_pkg::next_slot(tail_q) == head_q);
	assign more = (head_nx != tail_q);
	assign scan_end = (scan_q == tail_q);
	assign dup = (rd_data.sensor_id == item_q.sensor_id);
	assign elapsed = item_q.now_ms - stamp_q;
	assign data_rdy = ~item_q.status_byte[acrs_pkg::STATUS_RDY_BIT];
	assign timed_out = (elapsed >= {16'd0, timeout_ms});
	assign retire = data_rdy | timed_out;
	assign emit_go = emit_valid & out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			acrs_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (item.func == acrs_pkg::FUNC_ENQ) begin
						state_d = full ? acrs_pkg::ST_DROP : acrs_pkg::ST_SCAN_RD;
					end else begin
						state_d = empty ? acrs_pkg::ST_IDLE : acrs_pkg::ST_POLL_CMP;
					end
				end
			end
			acrs_pkg::ST_SCAN_RD: begin
				if (scan_end) begin
					state_d = empty ? acrs_pkg::ST_START_NEW : acrs_pkg::ST_IDLE;
				end else begin
					state_d = acrs_pkg::ST_SCAN_CMP;
				end
			end
			acrs_pkg::ST_SCAN_CMP: begin
				state_d = dup ? acrs_pkg::ST_IDLE : acrs_pkg::ST_SCAN_RD;
			end
			acrs_pkg::ST_DROP, acrs_pkg::ST_START_NEW, acrs_pkg::ST_START_OLD: begin
				if (out_free) begin
					state_d = acrs_pkg::ST_IDLE;
				end
			end
			acrs_pkg::ST_POLL_CMP: begin
				if (!retire) begin
					state_d = acrs_pkg::ST_IDLE;
				end else if (out_free) begin
					state_d = more ? acrs_pkg::ST_START_WAIT : acrs_pkg::ST_IDLE;
				end
			end
			acrs_pkg::ST_START_WAIT: begin
				state_d = acrs_pkg::ST_START_OLD;
			end
			default: begin
				state_d = acrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == acrs_pkg::ST_IDLE);
		emit_valid = 1'b0;
		emit = '0;
		rd_addr = head_q;
		ring_wr = '0;
		case (state_q)
			acrs_pkg::ST_SCAN_RD: begin
				rd_addr = scan_q;
				if (scan_end) begin
					ring_wr.en = 1'b1;
					ring_wr.addr = tail_q;
					ring_wr.data = {item_q.sensor_id, item_q.pos_channel,
						item_q.neg_channel, item_q.gain};
				end
			end
			acrs_pkg::ST_SCAN_CMP: begin
				rd_addr = scan_q;
			end
			acrs_pkg::ST_DROP: begin
				emit_valid = 1'b1;
				emit.kind = acrs_pkg::KIND_DROP;
				emit.sensor = item_q.sensor_id;
				emit.last = 1'b1;
			end
			acrs_pkg::ST_START_NEW: begin
				emit_valid = 1'b1;
				emit.kind = acrs_pkg::KIND_START;
				emit.sensor = item_q.sensor_id;
				emit.pos_channel = item_q.pos_channel;
				emit.neg_channel = item_q.neg_channel;
				emit.gain = item_q.gain;
				emit.last = 1'b1;
			end
			acrs_pkg::ST_POLL_CMP: begin
				emit_valid = retire;
				emit.kind = data_rdy ? acrs_pkg::KIND_RESULT : acrs_pkg::KIND_TIMEOUT;
				emit.sensor = rd_data.sensor_id;
				emit.value = data_rdy ? item_q.raw_data : 24'd0;
				emit.last = ~more;
			end
			acrs_pkg::ST_START_OLD: begin
				emit_valid = 1'b1;
				emit.kind = acrs_pkg::KIND_START;
				emit.sensor = rd_data.sensor_id;
				emit.pos_channel = rd_data.pos_channel;
				emit.neg_channel = rd_data.neg_channel;
				emit.gain = rd_data.gain;
				emit.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acrs_pkg::ST_IDLE;
			head_q <= '0;
			tail_q <= '0;
			scan_q <= '0;
			stamp_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				acrs_pkg::ST_IDLE: begin
					scan_q <= head_q;
				end
				acrs_pkg::ST_SCAN_RD: begin
					if (scan_end) begin
						tail_q <= acrs_pkg::next_slot(tail_q);
						if (empty) begin
							stamp_q <= item_q.now_ms;
						end
					end
				end
				acrs_pkg::ST_SCAN_CMP: begin
					if (!dup) begin
						scan_q <= acrs_pkg::next_slot(scan_q);
					end
				end
				acrs_pkg::ST_POLL_CMP: begin
					if (emit_go) begin
						head_q <= head_nx;
						if (more) begin
							stamp_q <= item_q.now_ms;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/adc_conversion_request_sequencer_unit.sv =====
// Top level of the ADC conversion request sequencer.
//
//   channel  | dir | words
//   cmd      | in  | enqueue or poll word, valid/ready
//   res      | out | start, result, timeout or drop word, valid/ready, last marks end
//   cfg      | in  | timeout_ms write, cfg_we/cfg_wdata
//
// Enqueue: duplicate scan, one ring read per queued entry, stops at a match; start word
//   into an empty ring, drop word when full.
// Poll: no word on an empty ring; result or timeout on retire, then start of any next entry.
// cmd.ready is high only between words; a held res word stalls the sequencer at its next issue.
// Reset clears pointers, start stamp and output valid; timeout_ms returns to 1000.
module adc_conversion_request_sequencer_unit (
	input logic clk,
	input logic arst_n,
	acrs_in_if.sink cmd,
	acrs_out_if.source res,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);

	logic [15:0] timeout_q;
	logic res_valid_q;
	acrs_pkg::emit_t res_q;
	acrs_pkg::item_t item;
	acrs_pkg::emit_t emit;
	logic emit_valid, out_free;
	acrs_pkg::ring_wr_t ring_wr;
	acrs_pkg::ptr_t rd_addr;
	acrs_pkg::entry_t rd_data;

	assign item.func = acrs_pkg::func_t'(cmd.func);
	assign item.sensor_id = cmd.sensor_id;
	assign item.pos_channel = cmd.pos_channel;
	assign item.neg_channel = cmd.neg_channel;
	assign item.gain = cmd.gain;
	assign item.status_byte = cmd.status_byte;
	assign item.raw_data = cmd.raw_data;
	assign item.now_ms = cmd.now_ms;

	assign out_free = ~res_valid_q | res.ready;

	acrs_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd.valid),
		.in_ready(cmd.ready),
		.item(item),
		.timeout_ms(timeout_q),
		.emit_valid(emit_valid),
		.emit(emit),
		.out_free(out_free),
		.ring_wr(ring_wr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	acrs_ring u_ring (
		.clk(clk),
		.wr(ring_wr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= acrs_pkg::TIMEOUT_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (emit_valid && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && out_free) begin
			res_q <= emit;
		end
	end

	assign res.valid = res_valid_q;
	assign res.kind = res_q.kind;
	assign res.out_sensor = res_q.sensor;
	assign res.out_pos_channel = res_q.pos_channel;
	assign res.out_neg_channel = res_q.neg_channel;
	assign res.out_gain = res_q.gain;
	assign res.value = res_q.value;
	assign res.last = res_q.last;

endmodule

// ===== sv/acrs_chk.sv =====
// Port-level checker for the sequencer, bound to the top level.
module acrs_chk (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic cmd_func,
	input logic res_valid,
	input logic res_ready,
	input logic [1:0] res_kind,
	input logic signed [23:0] res_value,
	input logic res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_value)
			&& $stable(res_last))
		else $error("res word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_func == acrs_pkg::FUNC_ENQ) |=> !cmd_ready)
		else $error("cmd ready right after an accepted enqueue word");

	a_no_accept_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !cmd_ready)
		else $error("cmd ready while a second res word is pending");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind != acrs_pkg::KIND_RESULT) |-> res_value == 24'sd0)
		else $error("nonzero value on a word that carries no conversion");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((res_kind == acrs_pkg::KIND_START) || (res_kind == acrs_pkg::KIND_DROP))
			|-> res_last)
		else $error("start or drop word without last");

endmodule

bind adc_conversion_request_sequencer_unit acrs_chk u_acrs_chk (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.cmd_func(cmd.func),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_kind(res.kind),
	.res_value(res.value),
	.res_last(res.last)
);

// ===== tb/adc_conversion_request_sequencer_unit_test.sv =====
// Self-checking testbench of the ADC conversion request sequencer: directed and random words.
`timescale 1ns / 100ps

module adc_conversion_request_sequencer_unit_test;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_WORDS = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	acrs_in_if cmd_if();
	acrs_out_if res_if();

	adc_conversion_request_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	acrs_pkg::item_t cmd_backlog[$];
	acrs_pkg::emit_t due_words[$];
	acrs_pkg::item_t cur_word;
	acrs_pkg::emit_t want_word;

	acrs_pkg::entry_t ring_shadow[acrs_pkg::QUEUE_DEPTH];
	acrs_pkg::ptr_t head_shadow = '0;
	acrs_pkg::ptr_t tail_shadow = '0;
	logic [31:0] stamp_shadow = '0;
	logic [15:0] timeout_shadow = acrs_pkg::TIMEOUT_RESET;

	logic [31:0] clock_ms = '0;
	int unsigned words_queued = 0;
	int unsigned words_in = 0;
	int unsigned words_out = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	logic idle_en = 1'b1;
	logic hold_res = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		int unsigned g;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			g = 0;
		end else if (r < 88) begin
			g = $urandom_range(1, 3);
		end else begin
			g = $urandom_range(8, 40);
		end
		return g;
	endfunction

	function automatic acrs_pkg::emit_t make_word(input acrs_pkg::kind_t k, input logic [3:0] s,
			input logic [3:0] p, input logic [3:0] n, input logic [2:0] g,
			input logic [23:0] v, input logic l);
		acrs_pkg::emit_t w;
		w.kind = k;
		w.sensor = s;
		w.pos_channel = p;
		w.neg_channel = n;
		w.gain = g;
		w.value = v;
		w.last = l;
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 100) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	task automatic advance_sequencer(input acrs_pkg::item_t w);
		acrs_pkg::entry_t e;
		acrs_pkg::entry_t h;
		acrs_pkg::emit_t r;
		logic hit;
		logic retire;
		logic [31:0] elapsed;
		if (w.func == acrs_pkg::FUNC_ENQ) begin
			e.sensor_id = w.sensor_id;
			e.pos_channel = w.pos_channel;
			e.neg_channel = w.neg_channel;
			e.gain = w.gain;
			if (acrs_pkg::next_slot(tail_shadow) == head_shadow) begin
				due_words.push_back(make_word(acrs_pkg::KIND_DROP, e.sensor_id, '0, '0, '0, '0,
					1'b1));
			end else begin
				hit = 1'b0;
				for (acrs_pkg::ptr_t p = head_shadow; p != tail_shadow;
						p = acrs_pkg::next_slot(p)) begin
					if (ring_shadow[p].sensor_id == e.sensor_id) begin
						hit = 1'b1;
					end
				end
				if (!hit) begin
					ring_shadow[tail_shadow] = e;
					if (tail_shadow == head_shadow) begin
						stamp_shadow = w.now_ms;
						due_words.push_back(make_word(acrs_pkg::KIND_START, e.sensor_id,
							e.pos_channel, e.neg_channel, e.gain, '0, 1'b1));
					end
					tail_shadow = acrs_pkg::next_slot(tail_shadow);
				end
			end
		end else if (head_shadow != tail_shadow) begin
			h = ring_shadow[head_shadow];
			elapsed = w.now_ms - stamp_shadow;
			retire = 1'b1;
			if (!w.status_byte[acrs_pkg::STATUS_RDY_BIT]) begin
				r = make_word(acrs_pkg::KIND_RESULT, h.sensor_id, '0, '0, '0, w.raw_data, 1'b1);
			end else if (elapsed >= {16'd0, timeout_shadow}) begin
				r = make_word(acrs_pkg::KIND_TIMEOUT, h.sensor_id, '0, '0, '0, '0, 1'b1);
			end else begin
				retire = 1'b0;
			end
			if (retire) begin
				head_shadow = acrs_pkg::next_slot(head_shadow);
				if (head_shadow != tail_shadow) begin
					r.last = 1'b0;
					due_words.push_back(r);
					stamp_shadow = w.now_ms;
					h = ring_shadow[head_shadow];
					due_words.push_back(make_word(acrs_pkg::KIND_START, h.sensor_id,
						h.pos_channel, h.neg_channel, h.gain, '0, 1'b1));
				end else begin
					due_words.push_back(r);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("word %0d: %s got 'h%0h want 'h%0h", words_out, name, got,
				want));
		end
	endtask

	task automatic push_word(input acrs_pkg::func_t f, input logic [3:0] sid,
			input logic [3:0] pos, input logic [3:0] neg, input logic [2:0] g,
			input logic [7:0] st, input logic [23:0] raw, input logic [31:0] now);
		acrs_pkg::item_t it;
		it.func = f;
		it.sensor_id = sid;
		it.pos_channel = pos;
		it.neg_channel = neg;
		it.gain = g;
		it.status_byte = st;
		it.raw_data = raw;
		it.now_ms = now;
		cmd_backlog.push_back(it);
		words_queued++;
	endtask

	task automatic queue_random(input int count);
		int unsigned enq_pct;
		int unsigned pool;
		int unsigned r;
		int unsigned t;
		logic [7:0] st;
		enq_pct = 50;
		pool = 16;
		t = {16'd0, timeout_shadow};
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				enq_pct = 25 * $urandom_range(1, 3);
				pool = $urandom_range(0, 1) ? 16 : 5;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				clock_ms = clock_ms + $urandom_range(0, t / 4);
			end else if (r < 80) begin
				clock_ms = clock_ms + t;
			end else if (r < 95) begin
				clock_ms = clock_ms + $urandom_range(t, 3 * t);
			end else begin
				clock_ms = $urandom;
			end
			st = 8'($urandom);
			st[acrs_pkg::STATUS_RDY_BIT] = ($urandom_range(0, 99) >= 40);
			push_word(($urandom_range(0, 99) < enq_pct) ? acrs_pkg::FUNC_ENQ : acrs_pkg::FUNC_POLL,
				4'($urandom_range(0, pool - 1)), 4'($urandom), 4'($urandom), 3'($urandom), st,
				24'($urandom), clock_ms);
		end
	endtask

	task automatic wait_drained();
		while (words_in != words_queued || due_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [15:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_shadow = v;
	endtask

	// request words: hold until accepted, then advance after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
			cmd_if.func <= 1'b0;
			cmd_if.sensor_id <= '0;
			cmd_if.pos_channel <= '0;
			cmd_if.neg_channel <= '0;
			cmd_if.gain <= '0;
			cmd_if.status_byte <= '0;
			cmd_if.raw_data <= '0;
			cmd_if.now_ms <= '0;
		end else begin
			if (cmd_if.valid && cmd_if.ready) begin
				advance_sequencer(cur_word);
				words_in++;
			end
			if (!cmd_if.valid || cmd_if.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					cmd_if.valid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					cur_word = cmd_backlog.pop_front();
					cmd_if.func <= cur_word.func;
					cmd_if.sensor_id <= cur_word.sensor_id;
					cmd_if.pos_channel <= cur_word.pos_channel;
					cmd_if.neg_channel <= cur_word.neg_channel;
					cmd_if.gain <= cur_word.gain;
					cmd_if.status_byte <= cur_word.status_byte;
					cmd_if.raw_data <= cur_word.raw_data;
					cmd_if.now_ms <= cur_word.now_ms;
					cmd_if.valid <= 1'b1;
					send_gap = idle_en ? pick_gap() : 0;
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// result words: compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("word %0d: kind %0d sensor %0d with none expected",
						words_out, res_if.kind, res_if.out_sensor));
				end else begin
					want_word = due_words.pop_front();
					check_field("kind", 32'(res_if.kind), 32'(want_word.kind));
					check_field("sensor", 32'(res_if.out_sensor), 32'(want_word.sensor));
					check_field("pos_channel", 32'(res_if.out_pos_channel),
						32'(want_word.pos_channel));
					check_field("neg_channel", 32'(res_if.out_neg_channel),
						32'(want_word.neg_channel));
					check_field("gain", 32'(res_if.out_gain), 32'(want_word.gain));
					check_field("value", 32'($unsigned(res_if.value)), 32'(want_word.value));
					check_field("last", 32'(res_if.last), 32'(want_word.last));
				end
				words_out++;
			end
			if (hold_res) begin
				res_if.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
				recv_gap = idle_en ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("adc_conversion_request_sequencer_unit test failed");
			$finish;
		end
	end

	initial begin
		forever begin
			repeat ($urandom_range(300, 900)) @(posedge clk);
			idle_en <= ~idle_en;
		end
	end

	// hold the result side long enough for the sequencer to back up
	initial begin
		wait (words_in >= 150);
		@(posedge clk);
		hold_res <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_res <= 1'b0;
	end

	initial begin
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'h00, 24'h000000, 32'd0);
		push_word(acrs_pkg::FUNC_ENQ, 4'd0, 4'd0, 4'd0, 3'd0, 8'h00, 24'h000000, 32'd100);
		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'hFF, 24'hFFFFFF, 32'd1099);
		push_word(acrs_pkg::FUNC_ENQ, 4'd15, 4'd15, 4'd15, 3'd7, 8'hFF, 24'hFFFFFF, 32'd1099);
		push_word(acrs_pkg::FUNC_ENQ, 4'd0, 4'd9, 4'd3, 3'd5, 8'h00, 24'h000000, 32'd1099);
		push_word(acrs_pkg::FUNC_ENQ, 4'd15, 4'd1, 4'd2, 3'd1, 8'h00, 24'h000000, 32'd1099);
		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'hFB, 24'h800000, 32'd1099);
		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'h04, 24'h123456, 32'd2099);
		for (int s = 1; s <= 7; s++) begin
			push_word(acrs_pkg::FUNC_ENQ, 4'(s), 4'($urandom), 4'($urandom), 3'($urandom),
				8'h00, 24'h000000, 32'd3000);
		end
		push_word(acrs_pkg::FUNC_ENQ, 4'd8, 4'd5, 4'd6, 3'd3, 8'h00, 24'h000000, 32'd3000);
		push_word(acrs_pkg::FUNC_ENQ, 4'd1, 4'd5, 4'd6, 3'd3, 8'h00, 24'h000000, 32'd3000);
		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'h00, 24'h7FFFFF, 32'hFFFF_FFFF);
		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'h00, 24'h000000, 32'hFFFF_FFFF);
		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'hFF, 24'h000000, 32'h0000_0100);
		push_word(acrs_pkg::FUNC_POLL, 4'd0, 4'd0, 4'd0, 3'd0, 8'hFF, 24'h000000, 32'd999);
		clock_ms = 32'd999;

		set_timeout(16'd1);
		queue_random(PHASE_WORDS);
		set_timeout(16'hFFFF);
		queue_random(PHASE_WORDS);
		set_timeout(16'($urandom_range(2, 5000)));
		queue_random(PHASE_WORDS);
		set_timeout(16'($urandom_range(100, 2000)));
		queue_random(PHASE_WORDS);
		wait_drained();

		if (errors == 0) begin
			$display("adc_conversion_request_sequencer_unit test passed");
		end else begin
			$display("adc_conversion_request_sequencer_unit test failed");
		end
		$finish;
	end

endmodule
